// File: hw/rtl/udpdmx_pkg.sv
// Shared types and constants for the UDP port demux table.
package udpdmx_pkg;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_DELIVER  = 2'd1;
	localparam logic [1:0] OP_RECEIVE  = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_BAD_IFACE  = 4'd1;
	localparam logic [3:0] ST_DUPLICATE  = 4'd2;
	localparam logic [3:0] ST_FULL       = 4'd3;
	localparam logic [3:0] ST_NO_MATCH   = 4'd4;
	localparam logic [3:0] ST_QUEUE_FULL = 4'd5;
	localparam logic [3:0] ST_BAD_SLOT   = 4'd6;
	localparam logic [3:0] ST_SLOT_FREE  = 4'd7;
	localparam logic [3:0] ST_EMPTY      = 4'd8;

	localparam logic [15:0] HEADER_BYTES = 16'd8;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  iface;
		logic [63:0] ip_upper;
		logic [63:0] ip_lower;
		logic [15:0] remote_port;
		logic [15:0] local_port;
		logic [4:0]  slot_index;
		logic [15:0] packet_handle;
		logic [15:0] udp_length;
		logic [15:0] buffer_length;
	} req_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [3:0]  slot_out;
		logic [15:0] handle_out;
		logic [15:0] data_length;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, clear scan
		logic scan;      // examine slot at scan index
		logic commit;    // perform update for the request
		logic rd_ring;   // read ring memory for receive
		logic finish;    // raise done for the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] opcode;
		logic       scan_last;
		logic       scan_stop;
	} sts_t;

endpackage

// File: hw/rtl/udpdmx_ctrl.sv
// Sequencer for the UDP port demux table.
module udpdmx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output udpdmx_pkg::cmd_t   cmd,
	input  udpdmx_pkg::sts_t   sts
);
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_COMMIT = 5'b00100,
		S_READ   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.opcode == udpdmx_pkg::OP_RECEIVE) begin
					cmd.rd_ring = 1'b1;
					state_d = S_READ;
				end else begin
					cmd.scan = 1'b1;
					if (sts.scan_last || sts.scan_stop) state_d = S_COMMIT;
				end
			end
			S_READ: state_d = S_COMMIT;
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

// File: hw/rtl/udpdmx_datapath.sv
// Slot table, ring memories and result formation for the UDP port demux table.
module udpdmx_datapath #(
	parameter int SLOTS       = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int IFACES      = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  udpdmx_pkg::req_t   req,
	input  udpdmx_pkg::cmd_t   cmd,
	output udpdmx_pkg::sts_t   sts,
	output logic               done,
	output udpdmx_pkg::rsp_t   rsp
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MD = SLOTS * QUEUE_DEPTH;
	localparam int MW = (MD > 1) ? $clog2(MD) : 1;

	udpdmx_pkg::req_t req_q;

	logic [SLOTS-1:0]  used_q;
	logic [2:0]        ifc_q  [SLOTS];
	logic [63:0]       hi_q   [SLOTS];
	logic [63:0]       lo_q   [SLOTS];
	logic [15:0]       rp_q   [SLOTS];
	logic [15:0]       lp_q   [SLOTS];
	logic [QW-1:0]     head_q [SLOTS];
	logic [QW-1:0]     tail_q [SLOTS];
	logic [CW-1:0]     cnt_q  [SLOTS];

	logic [15:0] mem_h [MD];
	logic [15:0] mem_l [MD];
	logic [15:0] rd_h_q, rd_l_q;

	logic [SW-1:0] idx_q;
	logic          free_vld_q, match_vld_q, dup_q;
	logic [SW-1:0] free_q, match_q;
	logic [3:0]    status_q;
	logic [3:0]    slot_q;
	logic [15:0]   hout_q, dlen_q;
	logic          done_q;

	// per-slot scan compares
	logic ep_eq, addr_eq, addr_zero, iface_bad;
	assign ep_eq = used_q[idx_q] && ifc_q[idx_q] == req_q.iface &&
		rp_q[idx_q] == req_q.remote_port && lp_q[idx_q] == req_q.local_port;
	assign addr_eq   = hi_q[idx_q] == req_q.ip_upper && lo_q[idx_q] == req_q.ip_lower;
	assign addr_zero = hi_q[idx_q] == 64'd0 && lo_q[idx_q] == 64'd0;
	assign iface_bad = 32'(req_q.iface) >= IFACES;

	assign sts.opcode    = req_q.opcode;
	assign sts.scan_last = (32'(idx_q) == SLOTS - 1);
	assign sts.scan_stop = (req_q.opcode == udpdmx_pkg::OP_REGISTER) ?
		(iface_bad || (ep_eq && addr_eq)) :
		(req_q.opcode == udpdmx_pkg::OP_DELIVER) ? (ep_eq && !addr_zero && addr_eq) :
		1'b1;

	logic          sidx_ok;
	logic [SW-1:0] rsl;
	assign sidx_ok = {27'd0, req_q.slot_index} < 32'(SLOTS);
	assign rsl     = req_q.slot_index[SW-1:0];

	logic [MW-1:0] rd_addr, wr_addr;
	assign rd_addr = MW'(32'(rsl) * QUEUE_DEPTH + 32'(head_q[rsl]));
	assign wr_addr = MW'(32'(match_q) * QUEUE_DEPTH + 32'(tail_q[match_q]));

	logic room, do_enq, reg_ok, rcv_ok;
	assign room   = 32'(cnt_q[match_q]) < QUEUE_DEPTH;
	assign do_enq = cmd.commit && req_q.opcode == udpdmx_pkg::OP_DELIVER && match_vld_q &&
		room;
	assign reg_ok = req_q.opcode == udpdmx_pkg::OP_REGISTER && !iface_bad && !dup_q &&
		free_vld_q;
	assign rcv_ok = req_q.opcode == udpdmx_pkg::OP_RECEIVE && sidx_ok && used_q[rsl] &&
		cnt_q[rsl] != '0;

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.rd_ring) begin
			rd_h_q <= mem_h[rd_addr];
			rd_l_q <= mem_l[rd_addr];
		end
		if (do_enq) begin
			mem_h[wr_addr] <= req_q.packet_handle;
			mem_l[wr_addr] <= req_q.udp_length;
		end
	end

	logic [15:0] pay;
	assign pay = (rd_l_q >= udpdmx_pkg::HEADER_BYTES) ? rd_l_q - udpdmx_pkg::HEADER_BYTES : 16'd0;

	logic [3:0] status_d;
	always_comb begin
		status_d = udpdmx_pkg::ST_NO_MATCH;
		case (req_q.opcode)
			udpdmx_pkg::OP_REGISTER: begin
				if (iface_bad) status_d = udpdmx_pkg::ST_BAD_IFACE;
				else if (dup_q) status_d = udpdmx_pkg::ST_DUPLICATE;
				else if (!free_vld_q) status_d = udpdmx_pkg::ST_FULL;
				else status_d = udpdmx_pkg::ST_OK;
			end
			udpdmx_pkg::OP_DELIVER: begin
				if (match_vld_q)
					status_d = room ? udpdmx_pkg::ST_OK : udpdmx_pkg::ST_QUEUE_FULL;
			end
			udpdmx_pkg::OP_RECEIVE: begin
				if (!sidx_ok) status_d = udpdmx_pkg::ST_BAD_SLOT;
				else if (!used_q[rsl]) status_d = udpdmx_pkg::ST_SLOT_FREE;
				else if (cnt_q[rsl] == '0) status_d = udpdmx_pkg::ST_EMPTY;
				else status_d = udpdmx_pkg::ST_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q <= '0;
			free_vld_q <= 1'b0;
			match_vld_q <= 1'b0;
			dup_q <= 1'b0;
			free_q <= '0;
			match_q <= '0;
			status_q <= '0;
			slot_q <= '0;
			hout_q <= '0;
			dlen_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				ifc_q[i] <= '0; hi_q[i] <= '0; lo_q[i] <= '0; rp_q[i] <= '0;
				lp_q[i] <= '0; head_q[i] <= '0; tail_q[i] <= '0; cnt_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				idx_q <= '0;
				free_vld_q <= 1'b0;
				match_vld_q <= 1'b0;
				dup_q <= 1'b0;
			end
			if (cmd.scan) begin
				if (!sts.scan_last && !sts.scan_stop) idx_q <= idx_q + 1'b1;
				if (req_q.opcode == udpdmx_pkg::OP_REGISTER) begin
					if (!used_q[idx_q] && !free_vld_q) begin
						free_vld_q <= 1'b1;
						free_q <= idx_q;
					end
					if (ep_eq && addr_eq) dup_q <= 1'b1;
				end else if (ep_eq && (addr_zero || addr_eq)) begin
					match_vld_q <= 1'b1;
					match_q <= idx_q;
				end
			end
			if (cmd.commit) begin
				status_q <= status_d;
				slot_q <= reg_ok ? 4'(free_q) :
					(req_q.opcode == udpdmx_pkg::OP_DELIVER && match_vld_q) ?
					4'(match_q) : 4'd0;
				hout_q <= rcv_ok ? rd_h_q : 16'd0;
				dlen_q <= !rcv_ok ? 16'd0 :
					(pay > req_q.buffer_length) ? req_q.buffer_length : pay;
				if (reg_ok) begin
					used_q[free_q] <= 1'b1;
					ifc_q[free_q] <= req_q.iface;
					hi_q[free_q] <= req_q.ip_upper;
					lo_q[free_q] <= req_q.ip_lower;
					rp_q[free_q] <= req_q.remote_port;
					lp_q[free_q] <= req_q.local_port;
					head_q[free_q] <= '0;
					tail_q[free_q] <= '0;
					cnt_q[free_q] <= '0;
				end
				if (do_enq) begin
					tail_q[match_q] <= (32'(tail_q[match_q]) + 1 >= QUEUE_DEPTH) ?
						'0 : tail_q[match_q] + 1'b1;
					cnt_q[match_q] <= cnt_q[match_q] + 1'b1;
				end
				if (rcv_ok) begin
					head_q[rsl] <= (32'(head_q[rsl]) + 1 >= QUEUE_DEPTH) ?
						'0 : head_q[rsl] + 1'b1;
					cnt_q[rsl] <= cnt_q[rsl] - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rsp.status      = status_q;
	assign rsp.slot_out    = slot_q;
	assign rsp.handle_out  = hout_q;
	assign rsp.data_length = dlen_q;
endmodule

// File: hw/rtl/udp_port_demux_table.sv
// Top level of the UDP port demux table.
// A request is taken when start is high and busy is low; its result is on rsp
// when done is high for one cycle, and cannot be held off. Register and
// deliver scan the slot table one slot per cycle, and the scan ends early on
// a bad interface, a duplicate or an exact match; receive skips the scan and
// takes the registered read of the ring memory. One request at a time.
module udp_port_demux_table #(
	parameter int SLOTS       = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int IFACES      = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  udpdmx_pkg::req_t   req,
	output logic               done,
	output udpdmx_pkg::rsp_t   rsp
);
	udpdmx_pkg::cmd_t cmd;
	udpdmx_pkg::sts_t sts;

	udpdmx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	udpdmx_datapath #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH), .IFACES(IFACES)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.done(done), .rsp(rsp)
	);
endmodule
